### design/ecsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecsr_pkg
// Shared sizes, request codes and status codes for the edge-list to CSR
// builder.
// ----------------------------------------------------------------------------
package ecsr_pkg;

    // Capacity of the vertex and edge stores.
    localparam int MAX_VERTS = 4096;
    localparam int MAX_EDGES = 4096;

    // Vertex id width, edge and vertex store address widths, count width, status width and request width.
    localparam int VID_W  = 12;
    localparam int EADR_W = $clog2(MAX_EDGES);
    localparam int VADR_W = $clog2(MAX_VERTS);
    localparam int CNT_W  = 13;
    localparam int STS_W  = 3;
    localparam int REQ_W  = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_FIELDS_W  = VID_W + VID_W + CNT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = CNT_W * 3 + STS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_ADD      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RD_OFF   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RD_NEIGH = 2'd3;

    // Response status codes.
    localparam logic [STS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STS_W-1:0] STS_SELF_LOOP = 3'd1;
    localparam logic [STS_W-1:0] STS_REFUSED   = 3'd2;
    localparam logic [STS_W-1:0] STS_BAD_INDEX = 3'd3;
    localparam logic [STS_W-1:0] STS_NOT_BUILT = 3'd4;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [VID_W-1:0] t_vid;

endpackage

### design/ecsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecsr_ram
// Simple dual-port RAM: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module ecsr_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/edge_list_to_csr_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_list_to_csr_builder
// Collects an edge list, counts degrees, and builds CSR offset and neighbour
// tables with a counting sort run by a small sequencer around one adder.
// ----------------------------------------------------------------------------
// Reset: after reset the degree store is swept to zero; no input
//   transaction is accepted during that sweep.
// Paths: an add edge reads and writes back the degree store, refused or trivial
//   requests go straight to the response, reads wait for registered table data.
// Build: a prefix sum pass over the vertices up to the largest id, then a
//   scatter pass over the stored edges; both passes use the degree store.
// One request is in flight at a time; the result register lets the next
//   request be accepted as soon as the previous result is registered.
// ----------------------------------------------------------------------------
module edge_list_to_csr_builder
    import ecsr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input tdata fields, low bit up: first_id, second_id, read_index.
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Input tuser fields, low bit up: req_type.
    input  logic [REQ_W-1:0]       i_s_axis_tuser,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // Output tdata fields, low bit up: read_value, vertex_count, edge_count,
    // status.
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready
);

    // Sequencer states.
    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_ADD_RD  = 4'd2;
    localparam logic [3:0] S_ADD_WR  = 4'd3;
    localparam logic [3:0] S_BLD0    = 4'd4;
    localparam logic [3:0] S_PRE_RD  = 4'd5;
    localparam logic [3:0] S_PRE_WR  = 4'd6;
    localparam logic [3:0] S_SC_RD1  = 4'd7;
    localparam logic [3:0] S_SC_RD2  = 4'd8;
    localparam logic [3:0] S_SC_WR   = 4'd9;
    localparam logic [3:0] S_RD_WAIT = 4'd10;
    localparam logic [3:0] S_RD_CAP  = 4'd11;
    localparam logic [3:0] S_RESP    = 4'd12;

    localparam int OFF_DEPTH = MAX_VERTS + 1;
    localparam int OADR_W    = $clog2(OFF_DEPTH);
    localparam int PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    // Control and payload registers.
    logic [3:0]             r_state, n_state;
    t_count                 r_cnt, n_cnt;
    t_vid                   r_largest, n_largest;
    t_count                 r_edges, n_edges;
    logic                   r_built, n_built;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic [REQ_W-1:0]       r_req, n_req;
    t_vid                   r_first, n_first;
    t_vid                   r_second, n_second;
    t_count                 r_idx, n_idx;
    t_count                 r_acc, n_acc;
    t_vid                   r_nb, n_nb;
    t_vid                   r_grp, n_grp;
    t_count                 r_val, n_val;
    logic [STS_W-1:0]       r_status, n_status;

    // Input fields.
    t_vid                   in_first;
    t_vid                   in_second;
    t_count                 in_idx;
    logic                   in_accept;

    // Memory ports.
    logic                   deg_we;
    logic [VADR_W-1:0]      deg_waddr, deg_raddr;
    t_count                 deg_wdata, deg_rdata;
    logic                   edge_we;
    logic [EADR_W-1:0]      edge_waddr, edge_raddr;
    logic [2*VID_W-1:0]     edge_wdata, edge_rdata;
    logic                   off_we;
    logic [OADR_W-1:0]      off_waddr, off_raddr;
    t_count                 off_wdata, off_rdata;
    logic                   nb_we;
    logic [EADR_W-1:0]      nb_waddr, nb_raddr;
    t_vid                   nb_wdata, nb_rdata;

    // Shared adder.
    t_count                 add_a, add_b, add_sum;

    // Derived values.
    t_count                 vert_count;
    t_vid                   max_in;

    assign in_first  = i_s_axis_tdata[VID_W-1:0];
    assign in_second = i_s_axis_tdata[2*VID_W-1:VID_W];
    assign in_idx    = i_s_axis_tdata[2*VID_W+CNT_W-1:2*VID_W];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign vert_count = {1'b0, r_largest} + t_count'(1);
    assign max_in     = (r_first > r_second) ? r_first : r_second;

    // The one adder serves degree increments, the prefix sum and the
    // fill cursor advance.
    always_comb begin
        if (r_state == S_PRE_WR) begin
            add_a = r_acc;
            add_b = deg_rdata;
        end else begin
            add_a = deg_rdata;
            add_b = t_count'(1);
        end
        add_sum = add_a + add_b;
    end

    // Sequencer next state and memory port control.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_largest   = r_largest;
        n_edges     = r_edges;
        n_built     = r_built;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_req       = r_req;
        n_first     = r_first;
        n_second    = r_second;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_nb        = r_nb;
        n_grp       = r_grp;
        n_val       = r_val;
        n_status    = r_status;

        deg_we      = 1'b0;
        deg_waddr   = r_cnt[VADR_W-1:0];
        deg_wdata   = '0;
        deg_raddr   = r_second;
        edge_we     = 1'b0;
        edge_waddr  = r_edges[EADR_W-1:0];
        edge_wdata  = {r_second, r_first};
        edge_raddr  = r_cnt[EADR_W-1:0];
        off_we      = 1'b0;
        off_waddr   = '0;
        off_wdata   = '0;
        off_raddr   = r_idx;
        nb_we       = 1'b0;
        nb_waddr    = deg_rdata[EADR_W-1:0];
        nb_wdata    = r_nb;
        nb_raddr    = r_idx[EADR_W-1:0];

        // The result register empties when the consumer takes it.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // Sweep the degree store to zero after reset.
            S_CLR: begin
                deg_we    = 1'b1;
                deg_waddr = r_cnt[VADR_W-1:0];
                deg_wdata = '0;
                if (r_cnt == t_count'(MAX_VERTS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + t_count'(1);
                end
            end

            // Take a request and decide its path.
            S_IDLE: begin
                if (in_accept) begin
                    n_req    = i_s_axis_tuser;
                    n_first  = in_first;
                    n_second = in_second;
                    n_idx    = in_idx;
                    n_val    = '0;
                    n_status = STS_OK;
                    case (i_s_axis_tuser)
                        REQ_ADD: begin
                            if (r_built || r_edges == t_count'(MAX_EDGES)) begin
                                n_status = STS_REFUSED;
                                n_state  = S_RESP;
                            end else if (in_first == in_second) begin
                                n_status = STS_SELF_LOOP;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_ADD_RD;
                            end
                        end
                        REQ_BUILD: begin
                            if (r_built) begin
                                n_state = S_RESP;
                            end else begin
                                n_state = S_BLD0;
                            end
                        end
                        REQ_RD_OFF: begin
                            if (!r_built) begin
                                n_status = STS_NOT_BUILT;
                                n_state  = S_RESP;
                            end else if (in_idx > vert_count) begin
                                n_status = STS_BAD_INDEX;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: begin
                            if (!r_built) begin
                                n_status = STS_NOT_BUILT;
                                n_state  = S_RESP;
                            end else if (in_idx >= r_edges) begin
                                n_status = STS_BAD_INDEX;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_RD_WAIT;
                            end
                        end
                    endcase
                end
            end

            // Degree read for the grouping vertex.
            S_ADD_RD: begin
                deg_raddr = r_second;
                n_state   = S_ADD_WR;
            end

            // Degree write-back, edge store write, running maximum.
            S_ADD_WR: begin
                deg_we     = 1'b1;
                deg_waddr  = r_second;
                deg_wdata  = add_sum;
                edge_we    = 1'b1;
                edge_waddr = r_edges[EADR_W-1:0];
                edge_wdata = {r_second, r_first};
                n_edges    = r_edges + t_count'(1);
                if (max_in > r_largest) begin
                    n_largest = max_in;
                end
                n_state = S_RESP;
            end

            // Start of build: the first offset is zero.
            S_BLD0: begin
                off_we    = 1'b1;
                off_waddr = '0;
                off_wdata = '0;
                n_cnt     = '0;
                n_acc     = '0;
                n_state   = S_PRE_RD;
            end

            // Prefix sum: read one degree.
            S_PRE_RD: begin
                deg_raddr = r_cnt[VADR_W-1:0];
                n_state   = S_PRE_WR;
            end

            // Prefix sum: write the next offset and turn the degree entry
            // into the fill cursor of that vertex.
            S_PRE_WR: begin
                deg_raddr = r_cnt[VADR_W-1:0];
                off_we    = 1'b1;
                off_waddr = OADR_W'(r_cnt + t_count'(1));
                off_wdata = add_sum;
                deg_we    = 1'b1;
                deg_waddr = r_cnt[VADR_W-1:0];
                deg_wdata = r_acc;
                n_acc     = add_sum;
                if (r_cnt[VADR_W-1:0] == r_largest) begin
                    n_cnt = '0;
                    if (r_edges == '0) begin
                        n_built = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SC_RD1;
                    end
                end else begin
                    n_cnt   = r_cnt + t_count'(1);
                    n_state = S_PRE_RD;
                end
            end

            // Scatter: fetch the next stored edge.
            S_SC_RD1: begin
                edge_raddr = r_cnt[EADR_W-1:0];
                n_state    = S_SC_RD2;
            end

            // Scatter: fetch the fill cursor of its group.
            S_SC_RD2: begin
                edge_raddr = r_cnt[EADR_W-1:0];
                deg_raddr  = edge_rdata[2*VID_W-1:VID_W];
                n_nb       = edge_rdata[VID_W-1:0];
                n_grp      = edge_rdata[2*VID_W-1:VID_W];
                n_state    = S_SC_WR;
            end

            // Scatter: place the neighbour and advance the cursor.
            S_SC_WR: begin
                deg_raddr = r_grp;
                nb_we     = (deg_rdata < t_count'(MAX_EDGES));
                nb_waddr  = deg_rdata[EADR_W-1:0];
                nb_wdata  = r_nb;
                deg_we    = 1'b1;
                deg_waddr = r_grp;
                deg_wdata = add_sum;
                if (r_cnt + t_count'(1) == r_edges) begin
                    n_cnt   = '0;
                    n_built = 1'b1;
                    n_state = S_RESP;
                end else begin
                    n_cnt   = r_cnt + t_count'(1);
                    n_state = S_SC_RD1;
                end
            end

            // Table read: address is presented this cycle.
            S_RD_WAIT: begin
                n_state = S_RD_CAP;
            end

            // Table read: capture the registered data.
            S_RD_CAP: begin
                if (r_req == REQ_RD_OFF) begin
                    n_val = off_rdata;
                end else begin
                    n_val = {1'b0, nb_rdata};
                end
                n_state = S_RESP;
            end

            // Load the result register once it is free.
            S_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{PAD_W{1'b0}}, r_status, r_edges, vert_count, r_val};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_largest   <= '0;
            r_edges     <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_largest   <= n_largest;
            r_edges     <= n_edges;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_req      <= n_req;
        r_first    <= n_first;
        r_second   <= n_second;
        r_idx      <= n_idx;
        r_acc      <= n_acc;
        r_nb       <= n_nb;
        r_grp      <= n_grp;
        r_val      <= n_val;
        r_status   <= n_status;
    end

    // Degree counts, later reused as the fill cursors.
    ecsr_ram #(.DEPTH(MAX_VERTS), .WIDTH(CNT_W)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    // Arrived edges: group id in the upper half, neighbour id in the lower.
    ecsr_ram #(.DEPTH(MAX_EDGES), .WIDTH(2 * VID_W)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    // CSR offset table.
    ecsr_ram #(.DEPTH(OFF_DEPTH), .WIDTH(CNT_W)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (off_waddr),
        .i_wdata (off_wdata),
        .i_raddr (off_raddr),
        .o_rdata (off_rdata)
    );

    // CSR neighbour table.
    ecsr_ram #(.DEPTH(MAX_EDGES), .WIDTH(VID_W)) u_nb_ram (
        .i_clk   (i_clk),
        .i_we    (nb_we),
        .i_waddr (nb_waddr),
        .i_wdata (nb_wdata),
        .i_raddr (nb_raddr),
        .o_rdata (nb_rdata)
    );

endmodule
